// ===== rtl/hlpd_pkg.sv =====
// Shared types, constants and codes for the handshake length-prefixed deframer.
package hlpd_pkg;

	localparam int HS_MAX_BYTES      = 8;
	localparam int HS_IDX_W          = 3;
	localparam int HS_LEN_W          = 4;
	localparam int HS_DATA_W         = 64;
	localparam int SIZE_LIMIT_W      = 32;
	localparam int LENGTH_WIDTH_DEF  = 32;
	localparam int CFG_DATA_W        = 64;
	localparam int CFG_INDEX_W       = 2;
	localparam int BYTE_W            = 8;
	localparam int KIND_W            = 3;
	localparam int QUEUE_DEPTH       = 2;
	localparam int QUEUE_PTR_W       = 1;
	localparam int QUEUE_CNT_W       = 2;

	localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [BYTE_W-1:0] DIGIT_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] DIGIT_NINE   = 8'h39;

	localparam logic [HS_DATA_W-1:0]    HS_BYTES_RST   = '0;
	localparam logic [HS_LEN_W-1:0]     HS_LEN_RST     = 4'd8;
	localparam logic [SIZE_LIMIT_W-1:0] SIZE_LIMIT_RST = 32'd1048576;

	typedef enum logic [1:0] {
		PH_HANDSHAKE,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD   = 3'd0,
		KIND_HS_OK     = 3'd1,
		KIND_EMPTY     = 3'd2,
		KIND_HS_ERR    = 3'd3,
		KIND_BAD_DIGIT = 3'd4,
		KIND_OVER      = 3'd5
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HS_BYTES   = 2'd0,
		REG_HS_LEN     = 2'd1,
		REG_SIZE_LIMIT = 2'd2
	} cfg_reg_t;

	// Classified received byte, as it travels through the queue
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_digit;
		logic              is_newline;
	} rx_class_t;

	// Queue status seen by the front and back parts
	typedef struct packed {
		logic full;
		logic valid;
	} queue_stat_t;

endpackage

// ===== rtl/hlpd_front.sv =====
// Front part: accepts received bytes and classifies them for the queue.
module hlpd_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [hlpd_pkg::BYTE_W-1:0] rx_byte,
	input  hlpd_pkg::queue_stat_t q_stat,
	output logic                  push,
	output hlpd_pkg::rx_class_t   push_data
);

	assign in_ready = !q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		push_data.data       = rx_byte;
		push_data.is_newline = (rx_byte == hlpd_pkg::NEWLINE_CHAR);
		push_data.is_digit   = (rx_byte >= hlpd_pkg::DIGIT_ZERO) &&
			(rx_byte <= hlpd_pkg::DIGIT_NINE);
	end

endmodule

// ===== rtl/hlpd_queue.sv =====
// Short queue of classified bytes between the front and back parts.
module hlpd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hlpd_pkg::rx_class_t   push_data,
	input  logic                  pop,
	output hlpd_pkg::rx_class_t   pop_data,
	output hlpd_pkg::queue_stat_t q_stat
);

	hlpd_pkg::rx_class_t                 mem_q [hlpd_pkg::QUEUE_DEPTH];
	logic [hlpd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [hlpd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [hlpd_pkg::QUEUE_CNT_W-1:0]    count_q;

	assign q_stat.full  = (count_q == hlpd_pkg::QUEUE_CNT_W'(hlpd_pkg::QUEUE_DEPTH));
	assign q_stat.valid = (count_q != '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/hlpd_back.sv =====
// Back part: handshake match, length parse, payload pass and result register.
module hlpd_back #(
	parameter int LENGTH_WIDTH = hlpd_pkg::LENGTH_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hlpd_pkg::queue_stat_t               q_stat,
	input  hlpd_pkg::rx_class_t                 q_data,
	output logic                                pop,
	input  logic [hlpd_pkg::HS_DATA_W-1:0]      hs_bytes,
	input  logic [hlpd_pkg::HS_LEN_W-1:0]       hs_len,
	input  logic [hlpd_pkg::SIZE_LIMIT_W-1:0]   size_limit,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hlpd_pkg::KIND_W-1:0]         kind,
	output logic [hlpd_pkg::BYTE_W-1:0]         payload_byte,
	output logic                                last,
	output logic                                is_handshaked
);

	localparam int NEXT_W = LENGTH_WIDTH + 4;
	localparam int CMP_W  = ((LENGTH_WIDTH > hlpd_pkg::SIZE_LIMIT_W) ?
		LENGTH_WIDTH : hlpd_pkg::SIZE_LIMIT_W) + 4;

	hlpd_pkg::phase_t                  phase_q, phase_d;
	logic [hlpd_pkg::HS_IDX_W-1:0]     idx_q, idx_d, idx_inc;
	logic [LENGTH_WIDTH-1:0]           accum_q, accum_d;
	logic [LENGTH_WIDTH-1:0]           left_q, left_d;
	logic [hlpd_pkg::HS_LEN_W-1:0]     hs_len_eff;
	logic [hlpd_pkg::BYTE_W-1:0]       want;
	logic [NEXT_W-1:0]                 accum_ext, accum_next;
	logic                              over;

	logic                              res_valid;
	hlpd_pkg::kind_t                   res_kind;
	logic [hlpd_pkg::BYTE_W-1:0]       res_byte;
	logic                              res_last;
	logic                              res_hs;

	logic                              out_valid_q;
	hlpd_pkg::kind_t                   kind_q;
	logic [hlpd_pkg::BYTE_W-1:0]       byte_q;
	logic                              last_q;
	logic                              hs_q;

	assign pop = q_stat.valid && (!out_valid_q || out_ready);

	always_comb begin
		if (hs_len == '0) begin
			hs_len_eff = hlpd_pkg::HS_LEN_W'(1);
		end else if (hs_len > hlpd_pkg::HS_LEN_W'(hlpd_pkg::HS_MAX_BYTES)) begin
			hs_len_eff = hlpd_pkg::HS_LEN_W'(hlpd_pkg::HS_MAX_BYTES);
		end else begin
			hs_len_eff = hs_len;
		end
	end

	assign want       = hs_bytes[idx_q*hlpd_pkg::BYTE_W +: hlpd_pkg::BYTE_W];
	assign idx_inc    = idx_q + 1'b1;
	assign accum_ext  = NEXT_W'(accum_q);
	assign accum_next = (accum_ext << 3) + (accum_ext << 1) + NEXT_W'(q_data.data[3:0]);
	assign over       = (accum_next[NEXT_W-1:LENGTH_WIDTH] != '0) ||
		(CMP_W'(accum_next) > CMP_W'(size_limit));

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		accum_d   = accum_q;
		left_d    = left_q;
		res_valid = 1'b0;
		res_kind  = hlpd_pkg::KIND_PAYLOAD;
		res_byte  = '0;
		res_last  = 1'b0;
		res_hs    = 1'b0;
		if (pop) begin
			unique case (phase_q)
				hlpd_pkg::PH_HANDSHAKE: begin
					if (q_data.data != want) begin
						phase_d   = hlpd_pkg::PH_ERROR;
						res_valid = 1'b1;
						res_kind  = hlpd_pkg::KIND_HS_ERR;
					end else if (idx_inc == '0 ||
						hlpd_pkg::HS_LEN_W'(idx_inc) >= hs_len_eff) begin
						idx_d     = '0;
						phase_d   = hlpd_pkg::PH_LENGTH;
						accum_d   = '0;
						res_valid = 1'b1;
						res_kind  = hlpd_pkg::KIND_HS_OK;
						res_hs    = 1'b1;
					end else begin
						idx_d = idx_inc;
					end
				end
				hlpd_pkg::PH_LENGTH: begin
					if (q_data.is_newline) begin
						if (accum_q == '0) begin
							res_valid = 1'b1;
							res_kind  = hlpd_pkg::KIND_EMPTY;
							res_last  = 1'b1;
							res_hs    = 1'b1;
						end else begin
							left_d  = accum_q;
							accum_d = '0;
							phase_d = hlpd_pkg::PH_PAYLOAD;
						end
					end else if (!q_data.is_digit) begin
						phase_d   = hlpd_pkg::PH_ERROR;
						res_valid = 1'b1;
						res_kind  = hlpd_pkg::KIND_BAD_DIGIT;
					end else if (over) begin
						phase_d   = hlpd_pkg::PH_ERROR;
						res_valid = 1'b1;
						res_kind  = hlpd_pkg::KIND_OVER;
					end else begin
						accum_d = accum_next[LENGTH_WIDTH-1:0];
					end
				end
				hlpd_pkg::PH_PAYLOAD: begin
					res_valid = 1'b1;
					res_kind  = hlpd_pkg::KIND_PAYLOAD;
					res_byte  = q_data.data;
					res_hs    = 1'b1;
					if (left_q <= LENGTH_WIDTH'(1)) begin
						res_last = 1'b1;
						left_d   = '0;
						accum_d  = '0;
						phase_d  = hlpd_pkg::PH_LENGTH;
					end else begin
						left_d = left_q - 1'b1;
					end
				end
				hlpd_pkg::PH_ERROR: begin
					// drop the byte
				end
				default: begin
					phase_d = hlpd_pkg::PH_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hlpd_pkg::PH_HANDSHAKE;
			idx_q       <= '0;
			accum_q     <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			accum_q <= accum_d;
			left_q  <= left_d;
			if (pop && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			kind_q <= res_kind;
			byte_q <= res_byte;
			last_q <= res_last;
			hs_q   <= res_hs;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign payload_byte  = byte_q;
	assign last          = last_q;
	assign is_handshaked = hs_q;

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == hlpd_pkg::PH_ERROR |=> phase_q == hlpd_pkg::PH_ERROR)
		else $error("error phase left without reset");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == hlpd_pkg::PH_PAYLOAD |-> left_q != '0)
		else $error("payload phase with no bytes left");

	a_hs_flag_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hs_q |-> kind_q != hlpd_pkg::KIND_HS_ERR &&
			kind_q != hlpd_pkg::KIND_BAD_DIGIT && kind_q != hlpd_pkg::KIND_OVER)
		else $error("handshaked flag set on an error result");

endmodule

// ===== rtl/handshake_length_prefixed_deframer_top.sv =====
// Top level of the handshake length-prefixed deframer with its register file.
// A byte accepted passes through the queue and then the result register before its result shows.
// One byte per cycle while the output is not stalled; the result register and a two-entry queue
// let input and output stall independently.
// Matched handshake bytes other than the last, digits and a newline ending a nonzero
// length produce no result; every payload byte produces one.
// Reset (arst_n low) clears phase, counters, queue and output valid at once, and
// loads the registers with their defaults; after an error only reset restarts it.
module handshake_length_prefixed_deframer_top #(
	parameter int LENGTH_WIDTH = hlpd_pkg::LENGTH_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [hlpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [hlpd_pkg::CFG_DATA_W-1:0]      cfg_data,
	// received byte channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [hlpd_pkg::BYTE_W-1:0]          rx_byte,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [hlpd_pkg::KIND_W-1:0]          kind,
	output logic [hlpd_pkg::BYTE_W-1:0]          payload_byte,
	output logic                                 last,
	output logic                                 is_handshaked
);

	// Configuration registers; the user must write them only while no transaction is in flight (unchecked)
	logic [hlpd_pkg::HS_DATA_W-1:0]    hs_bytes_q;
	logic [hlpd_pkg::HS_LEN_W-1:0]     hs_len_q;
	logic [hlpd_pkg::SIZE_LIMIT_W-1:0] size_limit_q;

	// Front to queue, queue to back
	hlpd_pkg::queue_stat_t q_stat;
	hlpd_pkg::rx_class_t   push_data;
	hlpd_pkg::rx_class_t   pop_data;
	logic                  push;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_bytes_q   <= hlpd_pkg::HS_BYTES_RST;
			hs_len_q     <= hlpd_pkg::HS_LEN_RST;
			size_limit_q <= hlpd_pkg::SIZE_LIMIT_RST;
		end else if (cfg_we) begin
			// Drop writes to indexes past the last register
			unique case (hlpd_pkg::cfg_reg_t'(cfg_index))
				hlpd_pkg::REG_HS_BYTES: begin
					hs_bytes_q <= cfg_data;
				end
				hlpd_pkg::REG_HS_LEN: begin
					hs_len_q <= cfg_data[hlpd_pkg::HS_LEN_W-1:0];
				end
				hlpd_pkg::REG_SIZE_LIMIT: begin
					size_limit_q <= cfg_data[hlpd_pkg::SIZE_LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Accept and classify each byte (newline, digit) as a transaction comes in
	hlpd_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Hold classified bytes so the parser can stall without blocking the input
	hlpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// Advance the handshake / length / payload machine and register results
	hlpd_back #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.q_data        (pop_data),
		.pop           (pop),
		.hs_bytes      (hs_bytes_q),
		.hs_len        (hs_len_q),
		.size_limit    (size_limit_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.last          (last),
		.is_handshaked (is_handshaked)
	);

endmodule

// ===== tb/handshake_length_prefixed_deframer_top_tb.sv =====
// Self-checking testbench for the handshake length-prefixed deframer top level.
`timescale 1ns / 100ps

module handshake_length_prefixed_deframer_top_tb;

	localparam int          RESET_CYCLES    = 10;
	localparam int          SETTLE_CYCLES   = 8;     // covers the queue and result register delay with margin
	localparam int          HOLD_OFF_CYCLES = 400;   // long receiver hold-off
	localparam int          WATCHDOG_LIMIT  = 5000;  // cycles without any transaction
	localparam int          RANDOM_ITEMS    = 1500;
	localparam int          RANDOM_PHASES   = 5;
	localparam int          NOISE_ITEMS     = 16;
	localparam logic [7:0]  CARRIAGE_RETURN = 8'h0D;
	localparam logic [63:0] LEN_MASK        =
		64'hFFFF_FFFF_FFFF_FFFF >> (64 - hlpd_pkg::LENGTH_WIDTH_DEF);

	// Ways to drive the deframer into its terminal error phase
	typedef enum logic [1:0] {
		FAULT_BAD_DIGIT,
		FAULT_CR,
		FAULT_OVER_LIMIT,
		FAULT_OVER_WIDTH
	} fault_t;

	// One expected result transaction
	typedef struct packed {
		hlpd_pkg::kind_t kind;
		logic [7:0]      payload;
		logic            last_flag;
		logic            handshaked;
	} deframe_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [hlpd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [hlpd_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                             in_valid;
	logic                             in_ready;
	logic [hlpd_pkg::BYTE_W-1:0]      rx_byte;
	logic                             out_valid;
	logic                             out_ready;
	logic [hlpd_pkg::KIND_W-1:0]      kind;
	logic [hlpd_pkg::BYTE_W-1:0]      payload_byte;
	logic                             last;
	logic                             is_handshaked;

	// Predictor copy of registers and state
	logic [63:0]       m_hs_bytes;
	logic [3:0]        m_hs_len;
	logic [31:0]       m_size_lim;
	hlpd_pkg::phase_t  m_phase;
	logic [2:0]        m_match;
	logic [63:0]       m_accum;
	logic [63:0]       m_left;

	deframe_result_t expected_results[$];
	deframe_result_t oldest;
	int unsigned     mismatch_count = 0;
	int unsigned     bytes_sent = 0;
	bit              tx_idle_on;
	bit              rx_idle_on;
	bit              stall_request;

	handshake_length_prefixed_deframer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.last          (last),
		.is_handshaked (is_handshaked)
	);

	always #10 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatch_count++;
		$display("%0t MISMATCH %s: got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Advance the deframer model by one received byte and queue what it emits
	function automatic void predict_deframe(input logic [7:0] b);
		deframe_result_t r;
		bit              produced;
		int unsigned     span;
		logic [63:0]     grown;
		logic [63:0]     ceiling;
		produced = 1'b0;
		r = '0;
		r.kind = hlpd_pkg::KIND_PAYLOAD;
		case (m_phase)
			hlpd_pkg::PH_HANDSHAKE: begin
				// a length of zero acts as one, anything past the maximum as the maximum
				span = (m_hs_len == 0) ? 1 :
					(m_hs_len > hlpd_pkg::HS_MAX_BYTES) ? hlpd_pkg::HS_MAX_BYTES : m_hs_len;
				if (b != m_hs_bytes[{m_match, 3'b000} +: 8]) begin
					m_phase = hlpd_pkg::PH_ERROR;
					r.kind = hlpd_pkg::KIND_HS_ERR;
					produced = 1'b1;
				end else begin
					m_match = m_match + 3'd1;
					if (m_match == 0 || m_match >= span) begin
						m_match = '0;
						m_phase = hlpd_pkg::PH_LENGTH;
						m_accum = '0;
						r.kind = hlpd_pkg::KIND_HS_OK;
						produced = 1'b1;
					end
				end
			end
			hlpd_pkg::PH_LENGTH: begin
				if (b == hlpd_pkg::NEWLINE_CHAR) begin
					if (m_accum == 0) begin
						r.kind = hlpd_pkg::KIND_EMPTY;
						r.last_flag = 1'b1;
						produced = 1'b1;
					end else begin
						m_left = m_accum;
						m_accum = '0;
						m_phase = hlpd_pkg::PH_PAYLOAD;
					end
				end else if (b < hlpd_pkg::DIGIT_ZERO || b > hlpd_pkg::DIGIT_NINE) begin
					m_phase = hlpd_pkg::PH_ERROR;
					r.kind = hlpd_pkg::KIND_BAD_DIGIT;
					produced = 1'b1;
				end else begin
					ceiling = {32'd0, m_size_lim};
					if (ceiling > LEN_MASK)
						ceiling = LEN_MASK;
					grown = m_accum * 64'd10 + 64'(b - hlpd_pkg::DIGIT_ZERO);
					if (grown > ceiling) begin
						m_phase = hlpd_pkg::PH_ERROR;
						r.kind = hlpd_pkg::KIND_OVER;
						produced = 1'b1;
					end else begin
						m_accum = grown;
					end
				end
			end
			hlpd_pkg::PH_PAYLOAD: begin
				r.payload = b;
				r.last_flag = (m_left <= 1);
				produced = 1'b1;
				if (r.last_flag) begin
					m_left = '0;
					m_phase = hlpd_pkg::PH_LENGTH;
					m_accum = '0;
				end else begin
					m_left = m_left - 1;
				end
			end
			default: ;
		endcase
		if (produced) begin
			r.handshaked = (m_phase == hlpd_pkg::PH_LENGTH || m_phase == hlpd_pkg::PH_PAYLOAD);
			expected_results.push_back(r);
		end
	endfunction

	// Offer one byte and hold it until the transaction completes, then maybe idle.
	// Valid stays high on return when no gap follows, so back-to-back bytes stream.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		rx_byte <= b;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		predict_deframe(b);
		bytes_sent++;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = idle_gap();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Length line (sometimes with leading zeros, sometimes blank for zero) then random payload
	task automatic send_message(input int unsigned n);
		int unsigned zeros;
		zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		if (n == 0 && $urandom_range(0, 1) == 0) begin
			send_byte(hlpd_pkg::NEWLINE_CHAR);
		end else begin
			repeat (zeros) send_byte(hlpd_pkg::DIGIT_ZERO);
			send_text($sformatf("%0d\n", n));
		end
		repeat (n) send_byte(8'($urandom));
	endtask

	// Drop valid, wait for every queued expectation, then let the pipeline settle
	task automatic wait_results_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input hlpd_pkg::cfg_reg_t idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			hlpd_pkg::REG_HS_BYTES:   m_hs_bytes = value;
			hlpd_pkg::REG_HS_LEN:     m_hs_len = value[3:0];
			hlpd_pkg::REG_SIZE_LIMIT: m_size_lim = value[31:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Match a random handshake; half the time change its length partway through
	task automatic test_handshake();
		bit rewrite;
		write_reg(hlpd_pkg::REG_HS_BYTES, {$urandom, $urandom});
		write_reg(hlpd_pkg::REG_HS_LEN, $urandom_range(0, 15));
		rewrite = $urandom_range(0, 1);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		while (m_phase == hlpd_pkg::PH_HANDSHAKE) begin
			send_byte(m_hs_bytes[{m_match, 3'b000} +: 8]);
			if (rewrite && m_phase == hlpd_pkg::PH_HANDSHAKE) begin
				// matched bytes give no result: the settle pause covers them
				rewrite = 1'b0;
				wait_results_done();
				write_reg(hlpd_pkg::REG_HS_LEN, $urandom_range(0, 15));
			end
		end
		wait_results_done();
	endtask

	// Directed length lines: zero, blank, single byte, leading zeros, exact limit
	task automatic test_length_lines();
		send_text("0\n");
		send_text("\n");
		send_text("1\n");
		send_byte(8'hFF);
		// payload may carry newlines and digits verbatim
		send_text("004\n");
		send_byte(8'h00);
		send_byte(hlpd_pkg::NEWLINE_CHAR);
		send_byte(hlpd_pkg::DIGIT_NINE);
		send_byte(8'h80);
		wait_results_done();
		write_reg(hlpd_pkg::REG_SIZE_LIMIT, 64'd3);
		send_text("3\n");
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h01);
		wait_results_done();
		write_reg(hlpd_pkg::REG_SIZE_LIMIT, 64'd0);
		send_text("00\n");
		send_text("\n");
		wait_results_done();
		write_reg(hlpd_pkg::REG_SIZE_LIMIT, 64'hFFFF_FFFF);
		send_text("12\n");
		repeat (12) send_byte(8'($urandom));
		wait_results_done();
	endtask

	// Random well-formed messages over several register settings and idle mixes
	task automatic test_random_messages();
		logic [31:0] limit_set [RANDOM_PHASES];
		logic [3:0]  len_set [RANDOM_PHASES];
		logic [63:0] pattern_set [RANDOM_PHASES];
		int unsigned goal;
		int unsigned cap;
		limit_set = '{32'hFFFF_FFFF, 32'd0, 32'd64, hlpd_pkg::SIZE_LIMIT_RST,
			32'($urandom_range(1, 20))};
		len_set = '{4'd0, 4'd15, 4'd1, 4'd8, 4'($urandom_range(2, 7))};
		pattern_set = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}};
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_results_done();
			// handshake registers no longer matter here but still take writes
			write_reg(hlpd_pkg::REG_SIZE_LIMIT, limit_set[ph]);
			write_reg(hlpd_pkg::REG_HS_LEN, len_set[ph]);
			write_reg(hlpd_pkg::REG_HS_BYTES, pattern_set[ph]);
			// first phase streams with no idling on either side
			tx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
			goal = bytes_sent + RANDOM_ITEMS / RANDOM_PHASES;
			while (bytes_sent < goal) begin
				cap = ($urandom_range(0, 9) == 0) ? 64 : 12;
				if (m_size_lim < cap)
					cap = m_size_lim;
				send_message($urandom_range(0, cap));
			end
		end
		wait_results_done();
	endtask

	// Hold the receiver off while the sender streams, then pause until all results drain
	task automatic test_backpressure();
		write_reg(hlpd_pkg::REG_SIZE_LIMIT, 64'hFFFF_FFFF);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		stall_request = 1'b1;
		send_message(40);
		wait_results_done();
	endtask

	// Force one terminal error, then show that further bytes are swallowed
	task automatic test_fatal_error();
		fault_t     fault;
		logic [7:0] b;
		fault = fault_t'($urandom_range(0, 3));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		case (fault)
			FAULT_BAD_DIGIT: begin
				repeat ($urandom_range(0, 2))
					send_byte(8'(hlpd_pkg::DIGIT_ZERO + $urandom_range(0, 9)));
				do
					b = 8'($urandom_range(0, 255));
				while ((b >= hlpd_pkg::DIGIT_ZERO && b <= hlpd_pkg::DIGIT_NINE) ||
					b == hlpd_pkg::NEWLINE_CHAR);
				send_byte(b);
			end
			FAULT_CR: begin
				send_text("12");
				send_byte(CARRIAGE_RETURN);
			end
			FAULT_OVER_LIMIT: begin
				write_reg(hlpd_pkg::REG_SIZE_LIMIT, $urandom_range(0, 1000));
				send_byte(8'(hlpd_pkg::DIGIT_ZERO + $urandom_range(1, 9)));
				while (m_phase == hlpd_pkg::PH_LENGTH)
					send_byte(8'(hlpd_pkg::DIGIT_ZERO + $urandom_range(0, 9)));
			end
			default: begin
				// one past the widest length the counter can hold
				write_reg(hlpd_pkg::REG_SIZE_LIMIT, 64'hFFFF_FFFF);
				send_text("4294967296");
			end
		endcase
		repeat (NOISE_ITEMS) send_byte(8'($urandom));
		wait_results_done();
	endtask

	// Receiver: random ready with occasional gaps, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				stall_request = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (idle_gap()) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Checker: compare each result transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending, kind", kind, '0);
			end else begin
				oldest = expected_results.pop_front();
				check_field("kind", kind, oldest.kind);
				check_field("payload_byte", payload_byte, oldest.payload);
				check_field("last", last, oldest.last_flag);
				check_field("is_handshaked", is_handshaked, oldest.handshaked);
			end
		end
	end

	// Watchdog: end the run once no transaction has happened for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		// drive every input to a known value before the first edge
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = hlpd_pkg::REG_HS_BYTES;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		stall_request = 1'b0;
		m_hs_bytes = hlpd_pkg::HS_BYTES_RST;
		m_hs_len = hlpd_pkg::HS_LEN_RST;
		m_size_lim = hlpd_pkg::SIZE_LIMIT_RST;
		m_phase = hlpd_pkg::PH_HANDSHAKE;
		m_match = '0;
		m_accum = '0;
		m_left = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_handshake();
		test_length_lines();
		test_random_messages();
		test_backpressure();
		test_fatal_error();

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
